// ----- hdl/rce_pkg.sv -----
// Shared types, codes and helpers for the result cache.
package rce_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam int ALG_W = 8;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CNT_W32 = 32;
  localparam int SLOT_W = 4;
  localparam int POL_W = 2;

  localparam int IN_TDATA_W = 72;
  localparam int OUT_TDATA_W = 104;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_SAVE = 1'b1;

  localparam logic [POL_W-1:0] POLICY_LFU = 2'd0;
  localparam logic [POL_W-1:0] POLICY_LRU = 2'd1;
  localparam logic [POL_W-1:0] POLICY_MRU = 2'd2;
  localparam logic [POL_W-1:0] POLICY_RESET = POLICY_LRU;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ctrl_sts_t;

  typedef struct packed {
    logic [ALG_W-1:0]   alg;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   result;
    logic [CNT_W32-1:0] use_count;
    logic [CNT_W32-1:0] last_use;
  } entry_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ----- hdl/result_cache_with_eviction.sv -----
// Top level of the fully associative result cache with selectable eviction.
//
// Each transfer on the in_ side is a lookup or a save of a result keyed by an
// algorithm number and a query key; each yields one transfer on the out_ side.
// An item is accepted, then the entry memory is scanned through its single
// registered read port at one entry per cycle, then the item is written back.
// The result is registered at write-back, and the next item can be accepted in
// the same cycle as the result is presented. The write-back waits while the
// previous result still waits on out_tready. One item is in flight at a time; a
// new item may be accepted while the previous result waits on out_tready. The
// eviction policy (0 least frequently used, 1 least recently used, 2 most
// recently used, 3 as 1) is written through cfg_wr_en; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module result_cache_with_eviction #(
  parameter int CACHE_ENTRIES = rce_pkg::ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // algorithm_id, query_key, result_value
  input  logic [rce_pkg::IN_TDATA_W-1:0]      in_tdata,
  // opcode
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // result_out, slot_written, evicted, total_hits, total_misses, zero pad
  output logic [rce_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // hit
  output logic                                out_tuser,
  input  logic                                cfg_wr_en,
  input  logic [rce_pkg::POL_W-1:0]           cfg_wr_data
);
  import rce_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  logic [VAL_W-1:0]  out_result;
  logic [SLOT_W-1:0] out_slot;
  logic              out_evicted;
  logic [31:0]       out_hits;
  logic [31:0]       out_misses;

  rce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rce_datapath #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_opcode   (in_tuser),
    .in_alg      (in_tdata[7:0]),
    .in_key      (in_tdata[39:8]),
    .in_val      (in_tdata[71:40]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_hit     (out_tuser),
    .out_result  (out_result),
    .out_slot    (out_slot),
    .out_evicted (out_evicted),
    .out_hits    (out_hits),
    .out_misses  (out_misses)
  );

  assign out_tdata = {3'b000, out_misses, out_hits, out_evicted, out_slot, out_result};

endmodule

// ----- hdl/rce_ctrl.sv -----
// Sequencing state machine for the result cache: accept, scan, write back.
module rce_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  rce_pkg::ctrl_sts_t  sts,
  output rce_pkg::ctrl_cmd_t  cmd
);
  import rce_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.start = in_tvalid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_WRITE: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/rce_datapath.sv -----
// Entry store, scan trackers, counters and result register of the result cache.
module rce_datapath #(
  parameter int CACHE_ENTRIES = rce_pkg::ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rce_pkg::ctrl_cmd_t              cmd,
  output rce_pkg::ctrl_sts_t              sts,
  input  logic                            in_opcode,
  input  logic [rce_pkg::ALG_W-1:0]       in_alg,
  input  logic [rce_pkg::KEY_W-1:0]       in_key,
  input  logic [rce_pkg::VAL_W-1:0]       in_val,
  input  logic                            cfg_wr_en,
  input  logic [rce_pkg::POL_W-1:0]       cfg_wr_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic [rce_pkg::VAL_W-1:0]       out_result,
  output logic [rce_pkg::SLOT_W-1:0]      out_slot,
  output logic                            out_evicted,
  output logic [31:0]                     out_hits,
  output logic [31:0]                     out_misses
);
  import rce_pkg::*;

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int ADR_W = $clog2(CACHE_ENTRIES + 1);

  entry_t mem_r [CACHE_ENTRIES];
  entry_t rd_data_r;
  logic [CACHE_ENTRIES-1:0] valid_r;

  logic             op_r;
  logic [ALG_W-1:0] alg_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  logic [ADR_W-1:0] addr_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             issue;

  logic             match_found_r;
  logic [IDX_W-1:0] match_idx_r;
  logic [31:0]      match_result_r;
  logic [31:0]      match_count_r;
  logic             empty_found_r;
  logic [IDX_W-1:0] empty_idx_r;
  logic             seen_r;
  logic [IDX_W-1:0] lfu_idx_r;
  logic [31:0]      lfu_cnt_r;
  logic [IDX_W-1:0] lru_idx_r;
  logic [31:0]      lru_stamp_r;
  logic [IDX_W-1:0] mru_idx_r;
  logic [31:0]      mru_stamp_r;

  logic [31:0] clock_r;
  logic [31:0] hits_r;
  logic [31:0] misses_r;
  logic [31:0] hits_nxt;
  logic [31:0] misses_nxt;
  logic [POL_W-1:0] policy_r;

  logic             cur_valid;
  logic             cur_match;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_entry;
  logic [IDX_W-1:0] victim_idx;
  logic [IDX_W-1:0] slot_idx;
  logic [IDX_W+SLOT_W-1:0] slot_ext;
  logic             hit_nxt;
  logic [VAL_W-1:0] result_nxt;
  logic             evicted_nxt;

  assign issue = cmd.scan && (addr_r < ADR_W'(CACHE_ENTRIES));
  assign cur_valid = valid_r[cmp_idx_r];
  assign cur_match = cur_valid && (rd_data_r.alg == alg_r) && (rd_data_r.key == key_r);

  assign sts.scan_done = cmp_vld_r && (cmp_idx_r == IDX_W'(CACHE_ENTRIES - 1));
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= in_opcode;
      alg_r <= in_alg;
      key_r <= in_key;
      val_r <= in_val;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem_r[addr_r[IDX_W-1:0]];
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r    <= '0;
      cmp_vld_r <= 1'b0;
      cmp_idx_r <= '0;
    end else if (cmd.start) begin
      addr_r    <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= issue;
      if (issue) begin
        cmp_idx_r <= addr_r[IDX_W-1:0];
        addr_r    <= addr_r + ADR_W'(1);
      end
    end
  end

  // track first match, first empty slot and replacement candidates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_found_r <= 1'b0;
      empty_found_r <= 1'b0;
      seen_r        <= 1'b0;
    end else if (cmd.start) begin
      match_found_r <= 1'b0;
      empty_found_r <= 1'b0;
      seen_r        <= 1'b0;
    end else if (cmp_vld_r) begin
      if (cur_match && !match_found_r) begin
        match_found_r  <= 1'b1;
        match_idx_r    <= cmp_idx_r;
        match_result_r <= rd_data_r.result;
        match_count_r  <= rd_data_r.use_count;
      end
      if (!cur_valid && !empty_found_r) begin
        empty_found_r <= 1'b1;
        empty_idx_r   <= cmp_idx_r;
      end
      if (cur_valid) begin
        seen_r <= 1'b1;
        if (!seen_r || (rd_data_r.use_count < lfu_cnt_r)) begin
          lfu_idx_r <= cmp_idx_r;
          lfu_cnt_r <= rd_data_r.use_count;
        end
        if (!seen_r || (rd_data_r.last_use < lru_stamp_r)) begin
          lru_idx_r   <= cmp_idx_r;
          lru_stamp_r <= rd_data_r.last_use;
        end
        if (!seen_r || (rd_data_r.last_use > mru_stamp_r)) begin
          mru_idx_r   <= cmp_idx_r;
          mru_stamp_r <= rd_data_r.last_use;
        end
      end
    end
  end

  always_comb begin
    case (policy_r)
      POLICY_LFU: victim_idx = lfu_idx_r;
      POLICY_MRU: victim_idx = mru_idx_r;
      default:    victim_idx = lru_idx_r;
    endcase
  end

  always_comb begin
    wr_en       = 1'b0;
    wr_idx      = match_idx_r;
    wr_entry    = '{alg: alg_r, key: key_r, result: val_r, use_count: 32'd1,
                    last_use: clock_r};
    hit_nxt     = 1'b0;
    result_nxt  = '0;
    slot_idx    = '0;
    evicted_nxt = 1'b0;
    hits_nxt    = hits_r;
    misses_nxt  = misses_r;
    if (op_r == OP_LOOKUP) begin
      if (match_found_r) begin
        hit_nxt            = 1'b1;
        result_nxt         = match_result_r;
        slot_idx           = match_idx_r;
        wr_en              = cmd.commit;
        wr_entry.result    = match_result_r;
        wr_entry.use_count = sat_inc(match_count_r);
        hits_nxt           = sat_inc(hits_r);
      end else begin
        misses_nxt = sat_inc(misses_r);
      end
    end else if (match_found_r) begin
      hit_nxt  = 1'b1;
      slot_idx = match_idx_r;
    end else begin
      slot_idx    = empty_found_r ? empty_idx_r : victim_idx;
      evicted_nxt = !empty_found_r;
      wr_en       = cmd.commit;
      wr_idx      = slot_idx;
    end
  end

  assign slot_ext = {{SLOT_W{1'b0}}, slot_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      clock_r  <= '0;
      hits_r   <= '0;
      misses_r <= '0;
    end else if (cmd.commit) begin
      if (wr_en) valid_r[wr_idx] <= 1'b1;
      clock_r  <= sat_inc(clock_r);
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_RESET;
    end else if (cfg_wr_en) begin
      policy_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit     <= hit_nxt;
      out_result  <= result_nxt;
      out_slot    <= slot_ext[SLOT_W-1:0];
      out_evicted <= evicted_nxt;
      out_hits    <= hits_nxt;
      out_misses  <= misses_nxt;
    end
  end

endmodule

// ----- dv/result_cache_with_eviction_tb.sv -----
// Self-checking testbench for the result cache: directed table, random phases per eviction policy.
`timescale 1ns / 1ps

module result_cache_with_eviction_tb;
  import rce_pkg::*;

  localparam int N_LINES = ENTRIES_DEF;
  localparam logic [POL_W-1:0] POLICY_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 25;

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
    logic [3:0]  slot;
    logic        evicted;
    logic [31:0] hits;
    logic [31:0] misses;
  } lookup_result_t;

  typedef struct {
    logic           op;
    logic [7:0]     alg;
    logic [31:0]    key;
    logic [31:0]    val;
    bit             typed;
    lookup_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_wr_en;
  logic [POL_W-1:0] cfg_wr_data;

  logic        line_valid [N_LINES];
  logic [7:0]  line_alg [N_LINES];
  logic [31:0] line_key [N_LINES];
  logic [31:0] line_result [N_LINES];
  logic [31:0] line_uses [N_LINES];
  logic [31:0] line_stamp [N_LINES];
  logic [31:0] access_clock;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [POL_W-1:0] policy;

  lookup_result_t awaited_results[$];
  stim_row_t directed_rows[$];
  int mismatch_count = 0;
  int burst_left = 1;
  int stall_run = 0;
  int stall_mode = 0;
  int rx_cycle = 0;

  result_cache_with_eviction dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic lookup_result_t cache_access(input logic op, input logic [7:0] alg,
                                                  input logic [31:0] key,
                                                  input logic [31:0] val);
    lookup_result_t r;
    bit found;
    bit empty;
    int slot;
    int lfu;
    int lru;
    int mru;
    logic [31:0] now;
    r = '0;
    found = 0;
    empty = 0;
    slot = 0;
    now = access_clock;
    for (int i = 0; i < N_LINES; i++) begin
      if (!found && line_valid[i] && line_alg[i] == alg && line_key[i] == key) begin
        found = 1;
        slot = i;
      end
    end
    if (op == OP_LOOKUP) begin
      if (found) begin
        r.hit = 1'b1;
        r.value = line_result[slot];
        line_uses[slot] = bump(line_uses[slot]);
        line_stamp[slot] = now;
        hit_total = bump(hit_total);
      end else begin
        miss_total = bump(miss_total);
      end
    end else if (found) begin
      r.hit = 1'b1;
    end else begin
      for (int i = 0; i < N_LINES; i++) begin
        if (!empty && !line_valid[i]) begin
          empty = 1;
          slot = i;
        end
      end
      if (!empty) begin
        lfu = 0;
        lru = 0;
        mru = 0;
        for (int i = 1; i < N_LINES; i++) begin
          if (line_uses[i] < line_uses[lfu]) lfu = i;
          if (line_stamp[i] < line_stamp[lru]) lru = i;
          if (line_stamp[i] > line_stamp[mru]) mru = i;
        end
        if (policy == POLICY_LFU) slot = lfu;
        else if (policy == POLICY_MRU) slot = mru;
        else slot = lru;
        r.evicted = 1'b1;
      end
      line_valid[slot] = 1'b1;
      line_alg[slot] = alg;
      line_key[slot] = key;
      line_result[slot] = val;
      line_uses[slot] = 32'd1;
      line_stamp[slot] = now;
    end
    access_clock = bump(access_clock);
    r.slot = slot[3:0];
    r.hits = hit_total;
    r.misses = miss_total;
    return r;
  endfunction

  function automatic stim_row_t row(input logic op, input logic [7:0] alg,
                                    input logic [31:0] key, input logic [31:0] val,
                                    input bit typed, input lookup_result_t want);
    stim_row_t s;
    s.op = op;
    s.alg = alg;
    s.key = key;
    s.val = val;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic lookup_result_t outcome(input logic hit, input logic [31:0] value,
                                             input logic [3:0] slot, input logic evicted,
                                             input logic [31:0] hits,
                                             input logic [31:0] misses);
    lookup_result_t r;
    r.hit = hit;
    r.value = value;
    r.slot = slot;
    r.evicted = evicted;
    r.hits = hits;
    r.misses = misses;
    return r;
  endfunction

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // call at a falling edge; returns at a falling edge with in_tvalid untouched in that step
  task automatic send_item(input logic op, input logic [7:0] alg, input logic [31:0] key,
                           input logic [31:0] val, input bit typed,
                           input lookup_result_t want);
    lookup_result_t predicted;
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {val, key, alg};
    do @(posedge clk); while (!in_tready);
    predicted = cache_access(op, alg, key, val);
    awaited_results.push_back(typed ? want : predicted);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (awaited_results.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_policy(input logic [POL_W-1:0] p);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    policy = p;
  endtask

  task automatic run_phase(input int count);
    logic [7:0] pool_alg [24];
    logic [31:0] pool_key [24];
    int pool_size;
    int pick;
    logic op;
    logic [7:0] alg;
    logic [31:0] key;
    pool_size = $urandom_range(10, 24);
    for (int i = 0; i < 24; i++) begin
      pool_alg[i] = 8'($urandom_range(0, 3));
      pool_key[i] = $urandom;
      if (i > 0 && $urandom_range(0, 3) == 0) pool_key[i] = pool_key[i-1];
    end
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(0, 99) < 55) ? OP_LOOKUP : OP_SAVE;
      if ($urandom_range(0, 99) < 85) begin
        pick = $urandom_range(0, pool_size - 1);
        alg = pool_alg[pick];
        key = pool_key[pick];
      end else begin
        alg = 8'($urandom_range(0, 255));
        key = $urandom;
      end
      send_item(op, alg, key, $urandom, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_run = $urandom_range(20, 200);
    end
    stall_run--;
    rx_cycle++;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= (rx_cycle % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit = out_tuser;
      got.value = out_tdata[31:0];
      got.slot = out_tdata[35:32];
      got.evicted = out_tdata[36];
      got.hits = out_tdata[68:37];
      got.misses = out_tdata[100:69];
      if (awaited_results.size() == 0) begin
        report("unexpected transfer", {63'd0, got.hit}, 64'd0);
      end else begin
        want = awaited_results.pop_front();
        if (got.hit !== want.hit) report("hit", 64'(got.hit), 64'(want.hit));
        if (got.value !== want.value)
          report("result_out", 64'(got.value), 64'(want.value));
        if (got.slot !== want.slot) report("slot_written", 64'(got.slot), 64'(want.slot));
        if (got.evicted !== want.evicted)
          report("evicted", 64'(got.evicted), 64'(want.evicted));
        if (got.hits !== want.hits) report("total_hits", 64'(got.hits), 64'(want.hits));
        if (got.misses !== want.misses)
          report("total_misses", 64'(got.misses), 64'(want.misses));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [POL_W-1:0] phase_policy [6];
    stim_row_t s;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_LOOKUP;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    for (int i = 0; i < N_LINES; i++) begin
      line_valid[i] = 1'b0;
      line_alg[i] = '0;
      line_key[i] = '0;
      line_result[i] = '0;
      line_uses[i] = '0;
      line_stamp[i] = '0;
    end
    access_clock = '0;
    hit_total = '0;
    miss_total = '0;
    policy = POLICY_RESET;

    directed_rows.push_back(row(OP_LOOKUP, 8'h00, 32'h0, 32'h0, 1'b1,
                                outcome(1'b0, 32'h0, 4'd0, 1'b0, 32'd0, 32'd1)));
    directed_rows.push_back(row(OP_SAVE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                outcome(1'b0, 32'h0, 4'd0, 1'b0, 32'd0, 32'd1)));
    directed_rows.push_back(row(OP_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 32'h0, 1'b1,
                                outcome(1'b1, 32'hFFFF_FFFF, 4'd0, 1'b0, 32'd1, 32'd1)));
    directed_rows.push_back(row(OP_SAVE, 8'hFF, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1,
                                outcome(1'b1, 32'h0, 4'd0, 1'b0, 32'd1, 32'd1)));
    directed_rows.push_back(row(OP_SAVE, 8'h00, 32'h0, 32'h0, 1'b1,
                                outcome(1'b0, 32'h0, 4'd1, 1'b0, 32'd1, 32'd1)));
    directed_rows.push_back(row(OP_LOOKUP, 8'h00, 32'h0, 32'hFFFF_FFFF, 1'b1,
                                outcome(1'b1, 32'h0, 4'd1, 1'b0, 32'd2, 32'd1)));
    directed_rows.push_back(row(OP_LOOKUP, 8'h00, 32'hFFFF_FFFF, 32'h0, 1'b1,
                                outcome(1'b0, 32'h0, 4'd0, 1'b0, 32'd2, 32'd2)));
    directed_rows.push_back(row(OP_LOOKUP, 8'hFF, 32'h0, 32'h0, 1'b1,
                                outcome(1'b0, 32'h0, 4'd0, 1'b0, 32'd2, 32'd3)));
    for (int i = 2; i < N_LINES; i++)
      directed_rows.push_back(row(OP_SAVE, i[7:0], 32'hA5A5_0000 + i, ~(32'hA5A5_0000 + i),
                                  1'b0, '0));
    directed_rows.push_back(row(OP_SAVE, 8'h5A, 32'h0F0F_F0F0, 32'hDEAD_0001, 1'b0, '0));
    directed_rows.push_back(row(OP_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 32'h0, 1'b0, '0));
    directed_rows.push_back(row(OP_LOOKUP, 8'h02, 32'hA5A5_0002, 32'h0, 1'b0, '0));

    phase_policy = '{POLICY_LFU, POLICY_MRU, POLICY_SPARE, POLICY_LRU, POLICY_LFU, POLICY_MRU};

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_policy(POLICY_LRU);

    foreach (directed_rows[i]) begin
      s = directed_rows[i];
      send_item(s.op, s.alg, s.key, s.val, s.typed, s.want);
    end
    drain();

    foreach (phase_policy[p]) begin
      write_policy(phase_policy[p]);
      run_phase(180);
      drain();
    end

    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- result_cache_with_eviction.f -----
hdl/rce_pkg.sv
hdl/rce_ctrl.sv
hdl/rce_datapath.sv
hdl/result_cache_with_eviction.sv
dv/result_cache_with_eviction_tb.sv
